### src/mstk_pkg.sv
`timescale 1ns / 1ps
package mstk_pkg;
  localparam int MAX_VERTICES = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PCLR,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_WALK_RD,
    ST_WALK_EDGE,
    ST_FIND_A,
    ST_FIND_B,
    ST_EMIT,
    ST_EMPTY
  } state_t;
endpackage

### src/minimum_spanning_tree_kruskal_unit.sv
`timescale 1ns / 1ps
// channel  | valid      | stall      | payload
// edge in  | edge_valid | edge_stall | edge_from, edge_to, edge_weight, edge_last
// tree out | tree_valid | tree_stall | tree_from, tree_to, tree_weight, tree_last,
//          |            |            | tree_empty, overflow
// config   | cfg_we     | -          | cfg_data (vertex_count)
// Edges load one per cycle into the edge memory.
// After the last edge: parent clear of all MAX_VERTICES entries, an insertion
// sort in the order memory, then a walk over the sorted edges with a find per
// endpoint and a union check.
// Each request out waits in the output register; the walk holds while it is full and stalled.
// rst is synchronous; it clears control state and sets the config register to 32.
module minimum_spanning_tree_kruskal_unit
  import mstk_pkg::*;
#(
  parameter int MAX_EDGES = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [5:0]                    cfg_data,
  input  logic                          edge_valid,
  output logic                          edge_stall,
  input  logic [4:0]                    edge_from,
  input  logic [4:0]                    edge_to,
  input  logic signed [WEIGHT_BITS-1:0] edge_weight,
  input  logic                          edge_last,
  output logic                          tree_valid,
  input  logic                          tree_stall,
  output logic [4:0]                    tree_from,
  output logic [4:0]                    tree_to,
  output logic signed [WEIGHT_BITS-1:0] tree_weight,
  output logic                          tree_last,
  output logic                          tree_empty,
  output logic                          overflow
);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EW = 10 + WEIGHT_BITS;

  logic [EW-1:0]  emem [MAX_EDGES];
  logic [EAW-1:0] omem [MAX_EDGES];
  logic [VAW-1:0] pmem [MAX_VERTICES];

  state_t state, state_next;
  logic [5:0]     vertex_count;
  logic [ECW-1:0] edge_count, edge_count_next;
  logic           ovf, ovf_next;
  logic [ECW-1:0] i, i_next;
  logic [ECW-1:0] j, j_next;
  logic [VCW-1:0] pc, pc_next;
  logic [VCW-1:0] chosen, chosen_next;
  logic [VCW-1:0] need;
  logic [VCW-1:0] vc;
  logic [WEIGHT_BITS-1:0] key, key_next;
  logic [4:0]     ea, ea_next, eb, eb_next;
  logic [WEIGHT_BITS-1:0] ew, ew_next;
  logic [VAW-1:0] x, x_next, ra, ra_next;
  logic           findb, findb_next;
  logic [VCW-1:0] steps, steps_next;
  logic           emit_pending, emit_pending_next;
  logic [4:0]     pend_from, pend_from_next, pend_to, pend_to_next;
  logic [WEIGHT_BITS-1:0] pend_w, pend_w_next;

  logic           e_we;
  logic [EAW-1:0] e_wa, e_ra;
  logic [EW-1:0]  e_wd, e_rd;
  logic           o_we;
  logic [EAW-1:0] o_wa, o_ra;
  logic [EAW-1:0] o_wd, o_rd;
  logic           p_we;
  logic [VAW-1:0] p_wa, p_ra;
  logic [VAW-1:0] p_wd, p_rd;

  logic           out_load;
  logic [4:0]     out_from, out_to;
  logic [WEIGHT_BITS-1:0] out_w;
  logic           out_last, out_empty;

  always_ff @(posedge clk) begin
    if (e_we) emem[e_wa] <= e_wd;
    e_rd <= emem[e_ra];
    if (o_we) omem[o_wa] <= o_wd;
    o_rd <= omem[o_ra];
    if (p_we) pmem[p_wa] <= p_wd;
    p_rd <= pmem[p_ra];
  end

  always_comb begin
    if (vertex_count == 6'd0) vc = VCW'(1);
    else if ({26'd0, vertex_count} > MAX_VERTICES) vc = VCW'(MAX_VERTICES);
    else vc = VCW'(vertex_count);
    need = vc - VCW'(1);
  end

  function automatic logic [WEIGHT_BITS-1:0] wkey(input logic [WEIGHT_BITS-1:0] w);
    wkey = {~w[WEIGHT_BITS-1], w[WEIGHT_BITS-2:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      vertex_count <= 6'd32;
      edge_count <= '0;
      ovf <= 1'b0;
      tree_valid <= 1'b0;
      emit_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_data;
      edge_count <= edge_count_next;
      ovf <= ovf_next;
      emit_pending <= emit_pending_next;
      if (out_load) tree_valid <= 1'b1;
      else if (!tree_stall) tree_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next; j <= j_next; pc <= pc_next; chosen <= chosen_next;
    key <= key_next; ea <= ea_next; eb <= eb_next; ew <= ew_next;
    x <= x_next; ra <= ra_next; findb <= findb_next; steps <= steps_next;
    pend_from <= pend_from_next; pend_to <= pend_to_next; pend_w <= pend_w_next;
    if (out_load) begin
      tree_from <= out_from;
      tree_to <= out_to;
      tree_weight <= out_w;
      tree_last <= out_last;
      tree_empty <= out_empty;
      overflow <= ovf;
    end
  end

  always_comb begin
    state_next = state;
    edge_count_next = edge_count; ovf_next = ovf;
    i_next = i; j_next = j; pc_next = pc; chosen_next = chosen;
    key_next = key; ea_next = ea; eb_next = eb; ew_next = ew;
    x_next = x; ra_next = ra; findb_next = findb; steps_next = steps;
    emit_pending_next = emit_pending;
    pend_from_next = pend_from; pend_to_next = pend_to; pend_w_next = pend_w;
    edge_stall = 1'b1;
    e_we = 1'b0; e_wa = edge_count[EAW-1:0];
    e_wd = {edge_from, edge_to, edge_weight};
    e_ra = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = x;
    out_load = 1'b0; out_from = pend_from; out_to = pend_to; out_w = pend_w;
    out_last = 1'b0; out_empty = 1'b0;
    unique case (state)
      ST_LOAD: begin
        edge_stall = 1'b0;
        if (edge_valid) begin
          if ({{(32-ECW){1'b0}}, edge_count} < MAX_EDGES) begin
            e_we = 1'b1;
            edge_count_next = edge_count + ECW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (edge_last) begin
            pc_next = '0;
            state_next = ST_PCLR;
          end
        end
      end
      ST_PCLR: begin
        p_we = 1'b1; p_wa = pc[VAW-1:0]; p_wd = pc[VAW-1:0];
        pc_next = pc + VCW'(1);
        if ({{(32-VCW){1'b0}}, pc} == MAX_VERTICES - 1) begin
          i_next = '0;
          state_next = ST_SORT_RD;
        end
      end
      ST_SORT_RD: begin
        // insert element i; read weight of i
        if (i == edge_count) begin
          i_next = '0; chosen_next = '0;
          state_next = ST_WALK_RD;
        end else begin
          e_ra = i[EAW-1:0];
          j_next = i;
          state_next = ST_SORT_CMP;
          findb_next = 1'b0;
        end
      end
      ST_SORT_CMP: begin
        // findb marks the compare phase: o_rd holds order[j-1]'s index, then e_rd its edge
        if (!findb) begin
          key_next = wkey(e_rd[WEIGHT_BITS-1:0]);
          if (j == '0) begin
            o_we = 1'b1; o_wa = '0; o_wd = i[EAW-1:0];
            i_next = i + ECW'(1);
            state_next = ST_SORT_RD;
          end else begin
            o_ra = EAW'(j - ECW'(1));
            findb_next = 1'b1;
            steps_next = '0;
          end
        end else if (steps == '0) begin
          e_ra = o_rd;
          o_ra = EAW'(j - ECW'(1));
          steps_next = VCW'(1);
        end else if (steps == VCW'(1)) begin
          steps_next = '0;
          if (wkey(e_rd[WEIGHT_BITS-1:0]) > key) begin
            o_we = 1'b1; o_wa = j[EAW-1:0]; o_wd = o_rd;
            j_next = j - ECW'(1);
            if (j == ECW'(1)) begin
              o_we = 1'b1;
              steps_next = VCW'(2);
            end else begin
              o_ra = EAW'(j - ECW'(2));
              steps_next = '0;
            end
          end else begin
            o_we = 1'b1; o_wa = j[EAW-1:0]; o_wd = i[EAW-1:0];
            i_next = i + ECW'(1);
            state_next = ST_SORT_RD;
          end
        end else begin
          o_we = 1'b1; o_wa = '0; o_wd = i[EAW-1:0];
          i_next = i + ECW'(1);
          state_next = ST_SORT_RD;
        end
      end
      ST_WALK_RD: begin
        if (i == edge_count || chosen == need) begin
          if (chosen == '0) state_next = ST_EMPTY;
          else if (!emit_pending) begin
            edge_count_next = '0; ovf_next = 1'b0;
            state_next = ST_LOAD;
          end else state_next = ST_EMIT;
        end else begin
          o_ra = i[EAW-1:0];
          steps_next = '0;
          state_next = ST_WALK_EDGE;
        end
      end
      ST_WALK_EDGE: begin
        if (steps == '0) begin
          e_ra = o_rd;
          steps_next = VCW'(1);
        end else begin
          ea_next = e_rd[EW-1 -: 5];
          eb_next = e_rd[EW-6 -: 5];
          ew_next = e_rd[WEIGHT_BITS-1:0];
          i_next = i + ECW'(1);
          if ({{(VCW-5){1'b0}}, e_rd[EW-1 -: 5]} >= vc ||
              {{(VCW-5){1'b0}}, e_rd[EW-6 -: 5]} >= vc) begin
            state_next = ST_WALK_RD;
          end else begin
            x_next = VAW'(e_rd[EW-1 -: 5]);
            findb_next = 1'b0;
            steps_next = '0;
            state_next = ST_FIND_A;
          end
        end
      end
      ST_FIND_A: begin
        // p_ra = x issued; next cycle p_rd = parent[x]
        if (steps == '0) begin
          steps_next = VCW'(1);
        end else if (p_rd == x) begin
          steps_next = '0;
          if (!findb) begin
            ra_next = x; findb_next = 1'b1; x_next = VAW'(eb);
          end else state_next = ST_FIND_B;
        end else begin
          x_next = p_rd; steps_next = '0;
        end
      end
      ST_FIND_B: begin
        if (x == ra) state_next = ST_WALK_RD;
        else if (emit_pending && tree_valid && tree_stall) begin
          state_next = ST_FIND_B;
        end else begin
          p_we = 1'b1; p_wa = x; p_wd = ra;
          // the previous choice goes out; this one waits to learn if it is last
          if (emit_pending) out_load = 1'b1;
          pend_from_next = ea; pend_to_next = eb; pend_w_next = ew;
          chosen_next = chosen + VCW'(1);
          emit_pending_next = 1'b1;
          state_next = ST_WALK_RD;
        end
      end
      ST_EMIT: begin
        if (!(tree_valid && tree_stall)) begin
          out_load = 1'b1; out_last = 1'b1;
          emit_pending_next = 1'b0;
          edge_count_next = '0; ovf_next = 1'b0;
          state_next = ST_LOAD;
        end
      end
      ST_EMPTY: begin
        if (!(tree_valid && tree_stall)) begin
          out_load = 1'b1; out_last = 1'b1; out_empty = 1'b1;
          out_from = '0; out_to = '0; out_w = '0;
          edge_count_next = '0; ovf_next = 1'b0;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end
endmodule

### src/mstk_checker.sv
`timescale 1ns / 1ps
module mstk_checker (
  input logic clk,
  input logic rst,
  input logic tree_valid,
  input logic tree_stall,
  input logic tree_last,
  input logic tree_empty,
  input logic [4:0] tree_from,
  input logic [4:0] tree_to,
  input logic edge_valid,
  input logic edge_stall,
  input logic edge_last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tree_valid && tree_stall |=> tree_valid && $stable(tree_from) && $stable(tree_to))
    else $error("stalled request changed");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    tree_valid && tree_empty |-> tree_last)
    else $error("empty request not last");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    tree_valid && tree_empty |-> tree_from == 5'd0 && tree_to == 5'd0)
    else $error("empty request has endpoints");
  a_no_self: assert property (@(posedge clk) disable iff (rst)
    tree_valid && !tree_empty |-> tree_from != tree_to)
    else $error("self loop chosen");
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    edge_valid && !edge_stall && edge_last |=> edge_stall)
    else $error("input open after last edge");
endmodule

bind minimum_spanning_tree_kruskal_unit mstk_checker u_mstk_checker (
  .clk(clk), .rst(rst), .tree_valid(tree_valid), .tree_stall(tree_stall),
  .tree_last(tree_last), .tree_empty(tree_empty), .tree_from(tree_from),
  .tree_to(tree_to), .edge_valid(edge_valid), .edge_stall(edge_stall),
  .edge_last(edge_last)
);
